### sv/ohlc_pkg.sv
// Shared types and constants for the tick to OHLC bar aggregator.
// Used by ohlc_front, ohlc_back, the top level and the testbench; depends on nothing.
package ohlc_pkg;

	// Stamp and key widths
	localparam int DATE_W = 27;
	localparam int TIME_W = 28;
	localparam int SEC_W  = 19;   // time / 1000
	localparam int MIN_W  = 12;   // time / 100000
	localparam int HOUR_W = 5;    // time / 10000000
	localparam int MON_W  = 21;   // date / 100
	localparam int YEAR_W = 14;   // date / 10000

	// Configuration widths
	localparam int UNIT_W     = 3;
	localparam int MULT_W     = 11;
	localparam int STALE_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int BCNT_W     = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_UNIT     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MULTIPLE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STALE_LIMIT     = 2'd2;

	// Configuration reset values
	localparam logic [MULT_W-1:0]  MULT_RESET  = 11'd1;
	localparam logic [STALE_W-1:0] STALE_RESET = 16'd180;

	// Stamp packing scales
	localparam int unsigned DATE_YEAR_SCALE  = 10000;
	localparam int unsigned DATE_MONTH_SCALE = 100;
	localparam int unsigned TIME_HOUR_SCALE  = 10000000;
	localparam int unsigned TIME_MIN_SCALE   = 100000;
	localparam int unsigned TIME_SEC_SCALE   = 1000;

	// Period normalization factors
	localparam int unsigned HOUR_TO_MIN = 60;
	localparam int unsigned WEEK_TO_DAY = 5;

	// Exact reciprocals: floor(x / d) = (x * ceil(2^s / d)) >> s for all x below 2^N,
	// with s = N + ceil(log2 d).
	localparam int RCP_W = 29;
	localparam logic [RCP_W-1:0] RCP_SEC  = 29'd274877907;  // 1/1000,     s = 38
	localparam logic [RCP_W-1:0] RCP_MIN  = 29'd351843721;  // 1/100000,   s = 45
	localparam logic [RCP_W-1:0] RCP_HOUR = 29'd450359963;  // 1/10000000, s = 52
	localparam logic [RCP_W-1:0] RCP_MON  = 29'd171798692;  // 1/100,      s = 34
	localparam logic [RCP_W-1:0] RCP_YEAR = 29'd219902326;  // 1/10000,    s = 41
	localparam int SH_SEC  = 38;
	localparam int SH_MIN  = 45;
	localparam int SH_HOUR = 52;
	localparam int SH_MON  = 34;
	localparam int SH_YEAR = 41;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [UNIT_W-1:0] {
		UNIT_MILLI, UNIT_SECOND, UNIT_MINUTE, UNIT_HOUR,
		UNIT_DAY, UNIT_WEEK, UNIT_MONTH, UNIT_YEAR
	} unit_t;

	typedef enum logic [1:0] {
		ST_STALE  = 2'd0,
		ST_UPDATE = 2'd1,
		ST_NEW    = 2'd2
	} status_t;

	// Classified tick stamp handed from the front to the back
	typedef struct packed {
		logic              stale;
		logic [DATE_W-1:0] date;
		logic [TIME_W-1:0] tod;
		logic [SEC_W-1:0]  sec_key;
		logic [MIN_W-1:0]  min_key;
		logic [HOUR_W-1:0] hour_key;
		logic [MON_W-1:0]  mon_key;
		logic [YEAR_W-1:0] year_key;
	} ohlc_stamp_t;

endpackage

### sv/tick_to_ohlc_bar_aggregator.sv
// Tick to OHLC bar aggregator, top level: configuration registers and the
// front end, item queue and bar update back end; depends on ohlc_pkg.
//
// Usage: ticks enter on in_valid/in_ready, one result item per tick leaves on
// out_valid/out_ready in the order the ticks were accepted. A stale tick yields
// status 0 with the current bar unchanged; otherwise status 1 updates the bar
// and status 2 reports a new bar, with the closed bar's volume when one closed.
// Configuration is written through cfg_we/cfg_index/cfg_data while no item is
// in flight; an index past the three registers is ignored.
// A tick passes two front stages (stamp packing, then reciprocal key products)
// and the queue into the result register. Throughput: one tick per cycle while
// the receiver does not stall, as the back end updates the bar on each pop.
// Reset clears the bar state and loads the configuration defaults (minute
// unit, multiple 1, stale limit 180 s); no clearing pass is needed.
// When the receiver stalls, the result register holds, the four-entry queue
// and the front stages fill, and in_ready drops once they are full.
module tick_to_ohlc_bar_aggregator #(
	parameter int PRICE_WIDTH  = 32,
	parameter int VOLUME_WIDTH = 40
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ohlc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ohlc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [13:0]                         tick_year,
	input  logic [3:0]                          tick_month,
	input  logic [4:0]                          tick_day,
	input  logic [4:0]                          tick_hour,
	input  logic [5:0]                          tick_minute,
	input  logic [5:0]                          tick_second,
	input  logic [9:0]                          tick_milli,
	input  logic [31:0]                         tick_unix_seconds,
	input  logic [31:0]                         now_unix_seconds,
	input  logic signed [PRICE_WIDTH-1:0]       close_price,
	input  logic [VOLUME_WIDTH-1:0]             cumulative_volume,
	input  logic [VOLUME_WIDTH-1:0]             open_interest,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          status,
	output logic signed [PRICE_WIDTH-1:0]       bar_open,
	output logic signed [PRICE_WIDTH-1:0]       bar_high,
	output logic signed [PRICE_WIDTH-1:0]       bar_low,
	output logic signed [PRICE_WIDTH-1:0]       bar_close,
	output logic [VOLUME_WIDTH-1:0]             bar_start_volume,
	output logic [VOLUME_WIDTH-1:0]             bar_open_interest,
	output logic [VOLUME_WIDTH-1:0]             closed_bar_volume,
	output logic                                closed_bar_valid,
	output logic [ohlc_pkg::DATE_W-1:0]         bar_date_stamp,
	output logic [ohlc_pkg::TIME_W-1:0]         bar_time_stamp
);
	import ohlc_pkg::*;

	localparam int STAMP_W = $bits(ohlc_stamp_t);
	localparam int QW      = STAMP_W + PRICE_WIDTH + 2 * VOLUME_WIDTH;

	unit_t                         period_unit_q;
	logic [MULT_W-1:0]             period_multiple_q;
	logic [STALE_W-1:0]            stale_limit_q;

	logic                          push_valid, push_ready;
	ohlc_stamp_t                   push_stamp;
	logic signed [PRICE_WIDTH-1:0] push_close;
	logic [VOLUME_WIDTH-1:0]       push_volume, push_interest;
	logic [QW-1:0]                 push_data, pop_data;
	logic                          pop_valid, pop_ready;
	ohlc_stamp_t                   pop_stamp;
	logic signed [PRICE_WIDTH-1:0] pop_close;
	logic [VOLUME_WIDTH-1:0]       pop_volume, pop_interest;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_unit_q     <= UNIT_MINUTE;
			period_multiple_q <= MULT_RESET;
			stale_limit_q     <= STALE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PERIOD_UNIT:     period_unit_q     <= unit_t'(cfg_data[UNIT_W-1:0]);
				CFG_PERIOD_MULTIPLE: period_multiple_q <= cfg_data[MULT_W-1:0];
				CFG_STALE_LIMIT:     stale_limit_q     <= cfg_data[STALE_W-1:0];
				default: ;
			endcase
		end
	end

	ohlc_front #(
		.PRICE_WIDTH  (PRICE_WIDTH),
		.VOLUME_WIDTH (VOLUME_WIDTH)
	) u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.tick_year         (tick_year),
		.tick_month        (tick_month),
		.tick_day          (tick_day),
		.tick_hour         (tick_hour),
		.tick_minute       (tick_minute),
		.tick_second       (tick_second),
		.tick_milli        (tick_milli),
		.tick_unix_seconds (tick_unix_seconds),
		.now_unix_seconds  (now_unix_seconds),
		.close_price       (close_price),
		.cumulative_volume (cumulative_volume),
		.open_interest     (open_interest),
		.stale_limit       (stale_limit_q),
		.push_valid        (push_valid),
		.push_ready        (push_ready),
		.push_stamp        (push_stamp),
		.push_close        (push_close),
		.push_volume       (push_volume),
		.push_interest     (push_interest)
	);

	// Pack and unpack queue items
	assign push_data = {push_stamp, push_close, push_volume, push_interest};
	assign {pop_stamp, pop_close, pop_volume, pop_interest} = pop_data;

	ohlc_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	ohlc_back #(
		.PRICE_WIDTH  (PRICE_WIDTH),
		.VOLUME_WIDTH (VOLUME_WIDTH)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.item_valid        (pop_valid),
		.item_ready        (pop_ready),
		.item_stamp        (pop_stamp),
		.item_close        (pop_close),
		.item_volume       (pop_volume),
		.item_interest     (pop_interest),
		.period_unit       (period_unit_q),
		.period_multiple   (period_multiple_q),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.status            (status),
		.bar_open          (bar_open),
		.bar_high          (bar_high),
		.bar_low           (bar_low),
		.bar_close         (bar_close),
		.bar_start_volume  (bar_start_volume),
		.bar_open_interest (bar_open_interest),
		.closed_bar_volume (closed_bar_volume),
		.closed_bar_valid  (closed_bar_valid),
		.bar_date_stamp    (bar_date_stamp),
		.bar_time_stamp    (bar_time_stamp)
	);

endmodule

### sv/ohlc_front.sv
// Front end: accepts ticks, checks staleness, packs stamps and derives boundary keys.
// Two pipeline stages feeding the item queue; depends on ohlc_pkg.
module ohlc_front #(
	parameter int PRICE_WIDTH  = 32,
	parameter int VOLUME_WIDTH = 40
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [13:0]                         tick_year,
	input  logic [3:0]                          tick_month,
	input  logic [4:0]                          tick_day,
	input  logic [4:0]                          tick_hour,
	input  logic [5:0]                          tick_minute,
	input  logic [5:0]                          tick_second,
	input  logic [9:0]                          tick_milli,
	input  logic [31:0]                         tick_unix_seconds,
	input  logic [31:0]                         now_unix_seconds,
	input  logic signed [PRICE_WIDTH-1:0]       close_price,
	input  logic [VOLUME_WIDTH-1:0]             cumulative_volume,
	input  logic [VOLUME_WIDTH-1:0]             open_interest,
	input  logic [ohlc_pkg::STALE_W-1:0]        stale_limit,
	output logic                                push_valid,
	input  logic                                push_ready,
	output ohlc_pkg::ohlc_stamp_t               push_stamp,
	output logic signed [PRICE_WIDTH-1:0]       push_close,
	output logic [VOLUME_WIDTH-1:0]             push_volume,
	output logic [VOLUME_WIDTH-1:0]             push_interest
);
	import ohlc_pkg::*;

	localparam int TP_W = TIME_W + RCP_W;
	localparam int DP_W = DATE_W + RCP_W;

	logic                          s1_valid_q;
	logic                          stale_s1;
	logic [DATE_W-1:0]             date_s1;
	logic [TIME_W-1:0]             tod_s1;
	logic signed [PRICE_WIDTH-1:0] close_s1;
	logic [VOLUME_WIDTH-1:0]       vol_s1;
	logic [VOLUME_WIDTH-1:0]       opi_s1;

	logic                          s2_valid_q;
	ohlc_stamp_t                   stamp_s2;
	logic signed [PRICE_WIDTH-1:0] close_s2;
	logic [VOLUME_WIDTH-1:0]       vol_s2;
	logic [VOLUME_WIDTH-1:0]       opi_s2;

	logic        s2_free;
	logic        accept;
	logic [31:0] gap;
	logic        stale;
	logic [31:0] date_sum;
	logic [31:0] time_sum;
	logic [TP_W-1:0] p_sec, p_min, p_hour;
	logic [DP_W-1:0] p_mon, p_year;

	// Pipeline handshake
	assign s2_free  = !s2_valid_q || push_ready;
	assign in_ready = !s1_valid_q || s2_free;
	assign accept   = in_valid && in_ready;

	// Check the tick time against the exchange clock
	assign gap   = (tick_unix_seconds > now_unix_seconds) ?
		(tick_unix_seconds - now_unix_seconds) : (now_unix_seconds - tick_unix_seconds);
	assign stale = gap > {{(32-STALE_W){1'b0}}, stale_limit};

	// Pack calendar stamps, then reduce to stamp width
	assign date_sum = 32'(tick_year) * 32'(DATE_YEAR_SCALE)
		+ 32'(tick_month) * 32'(DATE_MONTH_SCALE) + 32'(tick_day);
	assign time_sum = 32'(tick_hour) * 32'(TIME_HOUR_SCALE)
		+ 32'(tick_minute) * 32'(TIME_MIN_SCALE)
		+ 32'(tick_second) * 32'(TIME_SEC_SCALE) + 32'(tick_milli);

	// Stage 1: register classification and stamps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stale_s1 <= stale;
			date_s1  <= date_sum[DATE_W-1:0];
			tod_s1   <= time_sum[TIME_W-1:0];
			close_s1 <= close_price;
			vol_s1   <= cumulative_volume;
			opi_s1   <= open_interest;
		end
	end

	// Divide stamps by constants through reciprocal products
	assign p_sec  = TP_W'(tod_s1) * TP_W'(RCP_SEC);
	assign p_min  = TP_W'(tod_s1) * TP_W'(RCP_MIN);
	assign p_hour = TP_W'(tod_s1) * TP_W'(RCP_HOUR);
	assign p_mon  = DP_W'(date_s1) * DP_W'(RCP_MON);
	assign p_year = DP_W'(date_s1) * DP_W'(RCP_YEAR);

	// Stage 2: register boundary keys
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_free) begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_valid_q) begin
			stamp_s2.stale    <= stale_s1;
			stamp_s2.date     <= date_s1;
			stamp_s2.tod      <= tod_s1;
			stamp_s2.sec_key  <= p_sec[SH_SEC +: SEC_W];
			stamp_s2.min_key  <= p_min[SH_MIN +: MIN_W];
			stamp_s2.hour_key <= p_hour[SH_HOUR +: HOUR_W];
			stamp_s2.mon_key  <= p_mon[SH_MON +: MON_W];
			stamp_s2.year_key <= p_year[SH_YEAR +: YEAR_W];
			close_s2          <= close_s1;
			vol_s2            <= vol_s1;
			opi_s2            <= opi_s1;
		end
	end

	assign push_valid    = s2_valid_q;
	assign push_stamp    = stamp_s2;
	assign push_close    = close_s2;
	assign push_volume   = vol_s2;
	assign push_interest = opi_s2;

endmodule

### sv/ohlc_queue.sv
// Short item queue between the front end and the bar update logic.
// Register array with one read pointer; depends on nothing beyond its parameters.
module ohlc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [ADDR_W-1:0] wr_ptr_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the item
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### sv/ohlc_back.sv
// Back end: holds the bar state, counts unit boundaries and drives the result register.
// Pops classified items from ohlc_queue; depends on ohlc_pkg.
module ohlc_back #(
	parameter int PRICE_WIDTH  = 32,
	parameter int VOLUME_WIDTH = 40
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  ohlc_pkg::ohlc_stamp_t               item_stamp,
	input  logic signed [PRICE_WIDTH-1:0]       item_close,
	input  logic [VOLUME_WIDTH-1:0]             item_volume,
	input  logic [VOLUME_WIDTH-1:0]             item_interest,
	input  ohlc_pkg::unit_t                     period_unit,
	input  logic [ohlc_pkg::MULT_W-1:0]         period_multiple,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          status,
	output logic signed [PRICE_WIDTH-1:0]       bar_open,
	output logic signed [PRICE_WIDTH-1:0]       bar_high,
	output logic signed [PRICE_WIDTH-1:0]       bar_low,
	output logic signed [PRICE_WIDTH-1:0]       bar_close,
	output logic [VOLUME_WIDTH-1:0]             bar_start_volume,
	output logic [VOLUME_WIDTH-1:0]             bar_open_interest,
	output logic [VOLUME_WIDTH-1:0]             closed_bar_volume,
	output logic                                closed_bar_valid,
	output logic [ohlc_pkg::DATE_W-1:0]         bar_date_stamp,
	output logic [ohlc_pkg::TIME_W-1:0]         bar_time_stamp
);
	import ohlc_pkg::*;

	localparam int NMULT_W = MULT_W + 6;

	// Bar state
	logic                          has_bar_q;
	logic [BCNT_W-1:0]             bcnt_q;
	logic [DATE_W-1:0]             last_date_q;
	logic [TIME_W-1:0]             last_tod_q;
	logic [SEC_W-1:0]              last_sec_q;
	logic [MIN_W-1:0]              last_min_q;
	logic [HOUR_W-1:0]             last_hour_q;
	logic [MON_W-1:0]              last_mon_q;
	logic [YEAR_W-1:0]             last_year_q;
	logic signed [PRICE_WIDTH-1:0] open_q, high_q, low_q, close_q;
	logic [VOLUME_WIDTH-1:0]       start_vol_q, interest_q;
	logic [DATE_W-1:0]             start_date_q;
	logic [TIME_W-1:0]             start_tod_q;

	// Result register
	logic                          out_valid_q;
	status_t                       status_q;
	logic signed [PRICE_WIDTH-1:0] open_r_q, high_r_q, low_r_q, close_r_q;
	logic [VOLUME_WIDTH-1:0]       start_vol_r_q, interest_r_q, cvol_q;
	logic                          cvalid_q;
	logic [DATE_W-1:0]             start_date_r_q;
	logic [TIME_W-1:0]             start_tod_r_q;

	// Next values
	unit_t                         unit_n;
	logic [NMULT_W-1:0]            mult_full;
	logic [BCNT_W-1:0]             mult_n;
	logic                          crossed;
	logic [BCNT_W:0]               cnt_inc;
	logic                          wrap;
	logic                          fresh;
	logic                          pop;
	logic                          live;
	status_t                       nx_status;
	logic                          nx_has_bar;
	logic [BCNT_W-1:0]             nx_bcnt;
	logic signed [PRICE_WIDTH-1:0] nx_open, nx_high, nx_low, nx_close;
	logic [VOLUME_WIDTH-1:0]       nx_start_vol, nx_interest, nx_cvol;
	logic                          nx_cvalid;
	logic [DATE_W-1:0]             nx_start_date;
	logic [TIME_W-1:0]             nx_start_tod;

	assign item_ready = !out_valid_q || out_ready;
	assign pop        = item_valid && item_ready;
	assign live       = !item_stamp.stale;

	// Normalize hour to minutes and week to days, saturate the multiple
	always_comb begin
		case (period_unit)
			UNIT_HOUR: begin
				unit_n    = UNIT_MINUTE;
				mult_full = NMULT_W'(period_multiple) * NMULT_W'(HOUR_TO_MIN);
			end
			UNIT_WEEK: begin
				unit_n    = UNIT_DAY;
				mult_full = NMULT_W'(period_multiple) * NMULT_W'(WEEK_TO_DAY);
			end
			default: begin
				unit_n    = period_unit;
				mult_full = NMULT_W'(period_multiple);
			end
		endcase
		mult_n = (mult_full > NMULT_W'({BCNT_W{1'b1}})) ? {BCNT_W{1'b1}} : mult_full[BCNT_W-1:0];
	end

	// Detect a unit boundary against the previous non-stale stamp
	always_comb begin
		case (unit_n)
			UNIT_MILLI:  crossed = (item_stamp.date != last_date_q) ||
				(item_stamp.tod != last_tod_q);
			UNIT_SECOND: crossed = (item_stamp.date != last_date_q) ||
				(item_stamp.sec_key != last_sec_q);
			UNIT_MINUTE: crossed = (item_stamp.date != last_date_q) ||
				(item_stamp.min_key != last_min_q);
			UNIT_HOUR:   crossed = (item_stamp.date != last_date_q) ||
				(item_stamp.hour_key != last_hour_q);
			UNIT_DAY:    crossed = item_stamp.date != last_date_q;
			UNIT_MONTH:  crossed = item_stamp.mon_key != last_mon_q;
			UNIT_YEAR:   crossed = item_stamp.year_key != last_year_q;
			default:     crossed = 1'b0;
		endcase
	end

	// Advance the rollover counter and decide on a new bar
	assign cnt_inc = {1'b0, bcnt_q} + 1'b1;
	assign wrap    = cnt_inc >= {1'b0, mult_n};
	assign fresh   = !has_bar_q || (crossed && wrap);

	always_comb begin
		nx_status     = ST_STALE;
		nx_has_bar    = has_bar_q;
		nx_bcnt       = bcnt_q;
		nx_open       = open_q;
		nx_high       = high_q;
		nx_low        = low_q;
		nx_close      = close_q;
		nx_start_vol  = start_vol_q;
		nx_interest   = interest_q;
		nx_cvol       = '0;
		nx_cvalid     = 1'b0;
		nx_start_date = start_date_q;
		nx_start_tod  = start_tod_q;
		if (live) begin
			nx_has_bar  = 1'b1;
			nx_close    = item_close;
			nx_interest = item_interest;
			if (has_bar_q && crossed) begin
				nx_bcnt = wrap ? '0 : cnt_inc[BCNT_W-1:0];
			end
			if (fresh) begin
				nx_status     = ST_NEW;
				nx_open       = item_close;
				nx_high       = item_close;
				nx_low        = item_close;
				nx_start_vol  = item_volume;
				nx_start_date = item_stamp.date;
				nx_start_tod  = item_stamp.tod;
				if (has_bar_q) begin
					nx_cvol   = item_volume - start_vol_q;
					nx_cvalid = 1'b1;
				end
			end else begin
				nx_status = ST_UPDATE;
				if (item_close > high_q) begin
					nx_high = item_close;
				end
				if (item_close < low_q) begin
					nx_low = item_close;
				end
			end
		end
	end

	// Hold bar state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_bar_q    <= 1'b0;
			bcnt_q       <= '0;
			last_date_q  <= '0;
			last_tod_q   <= '0;
			last_sec_q   <= '0;
			last_min_q   <= '0;
			last_hour_q  <= '0;
			last_mon_q   <= '0;
			last_year_q  <= '0;
			open_q       <= '0;
			high_q       <= '0;
			low_q        <= '0;
			close_q      <= '0;
			start_vol_q  <= '0;
			interest_q   <= '0;
			start_date_q <= '0;
			start_tod_q  <= '0;
		end else if (pop && live) begin
			has_bar_q    <= nx_has_bar;
			bcnt_q       <= nx_bcnt;
			last_date_q  <= item_stamp.date;
			last_tod_q   <= item_stamp.tod;
			last_sec_q   <= item_stamp.sec_key;
			last_min_q   <= item_stamp.min_key;
			last_hour_q  <= item_stamp.hour_key;
			last_mon_q   <= item_stamp.mon_key;
			last_year_q  <= item_stamp.year_key;
			open_q       <= nx_open;
			high_q       <= nx_high;
			low_q        <= nx_low;
			close_q      <= nx_close;
			start_vol_q  <= nx_start_vol;
			interest_q   <= nx_interest;
			start_date_q <= nx_start_date;
			start_tod_q  <= nx_start_tod;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			status_q       <= nx_status;
			open_r_q       <= nx_open;
			high_r_q       <= nx_high;
			low_r_q        <= nx_low;
			close_r_q      <= nx_close;
			start_vol_r_q  <= nx_start_vol;
			interest_r_q   <= nx_interest;
			cvol_q         <= nx_cvol;
			cvalid_q       <= nx_cvalid;
			start_date_r_q <= nx_start_date;
			start_tod_r_q  <= nx_start_tod;
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign bar_open          = open_r_q;
	assign bar_high          = high_r_q;
	assign bar_low           = low_r_q;
	assign bar_close         = close_r_q;
	assign bar_start_volume  = start_vol_r_q;
	assign bar_open_interest = interest_r_q;
	assign closed_bar_volume = cvol_q;
	assign closed_bar_valid  = cvalid_q;
	assign bar_date_stamp    = start_date_r_q;
	assign bar_time_stamp    = start_tod_r_q;

endmodule

### sim/tb_tick_to_ohlc_bar_aggregator.sv
// Self-checking testbench for tick_to_ohlc_bar_aggregator: random-gap ticks in,
// random-stall results out, each result checked against an in-bench bar predictor.
// Depends on ohlc_pkg and the aggregator RTL only.
module tb_tick_to_ohlc_bar_aggregator;
	import ohlc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;   // unmapped register index
	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int unsigned NUM_PHASES      = 18;
	localparam int unsigned ITEMS_PER_PHASE = 50;
	localparam int unsigned DRAIN_CYCLES    = 8;
	localparam int unsigned MAX_REPORTS     = 10;

	typedef struct packed {
		logic [13:0]        year;
		logic [3:0]         month;
		logic [4:0]         day;
		logic [4:0]         hour;
		logic [5:0]         minute;
		logic [5:0]         second;
		logic [9:0]         milli;
		logic [31:0]        tick_unix;
		logic [31:0]        now_unix;
		logic signed [31:0] close;
		logic [39:0]        cum_vol;
		logic [39:0]        oi;
	} tick_t;

	typedef struct packed {
		status_t            st;
		logic signed [31:0] px_open;
		logic signed [31:0] px_high;
		logic signed [31:0] px_low;
		logic signed [31:0] px_close;
		logic [39:0]        start_vol;
		logic [39:0]        oi;
		logic [39:0]        closed_vol;
		logic               closed_valid;
		logic [DATE_W-1:0]  date;
		logic [TIME_W-1:0]  tod;
	} bar_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	tick_t                 tick_r = '0;

	logic [13:0]           tick_year;
	logic [3:0]            tick_month;
	logic [4:0]            tick_day;
	logic [4:0]            tick_hour;
	logic [5:0]            tick_minute;
	logic [5:0]            tick_second;
	logic [9:0]            tick_milli;
	logic [31:0]           tick_unix_seconds;
	logic [31:0]           now_unix_seconds;
	logic signed [31:0]    close_price;
	logic [39:0]           cumulative_volume;
	logic [39:0]           open_interest;
	logic [1:0]            status;
	logic signed [31:0]    bar_open;
	logic signed [31:0]    bar_high;
	logic signed [31:0]    bar_low;
	logic signed [31:0]    bar_close;
	logic [39:0]           bar_start_volume;
	logic [39:0]           bar_open_interest;
	logic [39:0]           closed_bar_volume;
	logic                  closed_bar_valid;
	logic [DATE_W-1:0]     bar_date_stamp;
	logic [TIME_W-1:0]     bar_time_stamp;

	assign tick_year         = tick_r.year;
	assign tick_month        = tick_r.month;
	assign tick_day          = tick_r.day;
	assign tick_hour         = tick_r.hour;
	assign tick_minute       = tick_r.minute;
	assign tick_second       = tick_r.second;
	assign tick_milli        = tick_r.milli;
	assign tick_unix_seconds = tick_r.tick_unix;
	assign now_unix_seconds  = tick_r.now_unix;
	assign close_price       = tick_r.close;
	assign cumulative_volume = tick_r.cum_vol;
	assign open_interest     = tick_r.oi;

	tick_to_ohlc_bar_aggregator u_dut (.*);

	always #2 clk = ~clk;

	// Predictor copy of the configuration registers
	unit_t              unit_cfg = UNIT_MINUTE;
	logic [MULT_W-1:0]  mult_cfg = MULT_RESET;
	logic [STALE_W-1:0] stale_cfg = STALE_RESET;

	// Predictor copy of the bar state
	logic               bar_live = 1'b0;
	int unsigned        roll_count = 0;
	logic [DATE_W-1:0]  prev_date = '0;
	logic [TIME_W-1:0]  prev_tod = '0;
	logic signed [31:0] open_px = '0;
	logic signed [31:0] high_px = '0;
	logic signed [31:0] low_px = '0;
	logic signed [31:0] last_px = '0;
	logic [39:0]        base_vol = '0;
	logic [39:0]        last_oi = '0;
	logic [DATE_W-1:0]  start_date = '0;
	logic [TIME_W-1:0]  start_tod = '0;

	tick_t       pending_ticks[$];
	bar_t        expected_bars[$];
	tick_t       walk = '0;
	int unsigned tx_gap = 0;
	int unsigned rx_gap = 0;
	logic        tx_calm = 1'b0;
	logic        rx_calm = 1'b0;
	int unsigned bad_results = 0;
	int unsigned results_seen = 0;

	function automatic int unsigned draw_gap(logic calm);
		return calm ? 0 : $urandom_range(0, 17);
	endfunction

	// Has the stamp left the previous tick's unit bucket?
	function automatic logic stamp_crossed(unit_t unit, logic [DATE_W-1:0] date,
			logic [TIME_W-1:0] tod);
		case (unit)
			UNIT_MILLI:  return date != prev_date || tod != prev_tod;
			UNIT_SECOND: return date != prev_date
				|| prev_tod / TIME_SEC_SCALE != tod / TIME_SEC_SCALE;
			UNIT_MINUTE: return date != prev_date
				|| prev_tod / TIME_MIN_SCALE != tod / TIME_MIN_SCALE;
			UNIT_HOUR:   return date != prev_date
				|| prev_tod / TIME_HOUR_SCALE != tod / TIME_HOUR_SCALE;
			UNIT_DAY:    return date != prev_date;
			UNIT_MONTH:  return prev_date / DATE_MONTH_SCALE != date / DATE_MONTH_SCALE;
			UNIT_YEAR:   return prev_date / DATE_YEAR_SCALE != date / DATE_YEAR_SCALE;
			default:     return 1'b0;
		endcase
	endfunction

	// Apply one accepted tick to the bar state and return the result it yields
	function automatic bar_t predict_bar(tick_t tk);
		logic [31:0]       skew;
		logic [31:0]       dsum;
		logic [31:0]       tsum;
		logic [DATE_W-1:0] date;
		logic [TIME_W-1:0] tod;
		unit_t             unit;
		int unsigned       span;
		int unsigned       nxt;
		logic              start;
		bar_t              r;
		skew = tk.tick_unix > tk.now_unix ? tk.tick_unix - tk.now_unix
			: tk.now_unix - tk.tick_unix;
		r = '0;
		r.st = ST_STALE;
		if (skew <= 32'(stale_cfg)) begin
			dsum = 32'(tk.year) * DATE_YEAR_SCALE + 32'(tk.month) * DATE_MONTH_SCALE
				+ 32'(tk.day);
			tsum = 32'(tk.hour) * TIME_HOUR_SCALE + 32'(tk.minute) * TIME_MIN_SCALE
				+ 32'(tk.second) * TIME_SEC_SCALE + 32'(tk.milli);
			date = dsum[DATE_W-1:0];
			tod = tsum[TIME_W-1:0];
			// Fold hour into minutes and week into days
			unit = unit_cfg;
			span = 32'(mult_cfg);
			if (unit == UNIT_HOUR) begin
				unit = UNIT_MINUTE;
				span = span * HOUR_TO_MIN;
			end else if (unit == UNIT_WEEK) begin
				unit = UNIT_DAY;
				span = span * WEEK_TO_DAY;
			end
			if (span > 65535) span = 65535;
			r.st = ST_UPDATE;
			start = !bar_live;
			if (bar_live && stamp_crossed(unit, date, tod)) begin
				nxt = roll_count + 1;
				roll_count = nxt >= span ? 0 : nxt;
				start = roll_count == 0;
			end
			// Close the running bar, if any, and open a new one at this price
			if (start) begin
				if (bar_live) begin
					r.closed_vol = tk.cum_vol - base_vol;
					r.closed_valid = 1'b1;
				end
				bar_live = 1'b1;
				base_vol = tk.cum_vol;
				open_px = tk.close;
				high_px = tk.close;
				low_px = tk.close;
				start_date = date;
				start_tod = tod;
				r.st = ST_NEW;
			end
			last_oi = tk.oi;
			last_px = tk.close;
			if (tk.close > high_px) high_px = tk.close;
			if (tk.close < low_px) low_px = tk.close;
			prev_date = date;
			prev_tod = tod;
		end
		r.px_open = open_px;
		r.px_high = high_px;
		r.px_low = low_px;
		r.px_close = last_px;
		r.start_vol = base_vol;
		r.oi = last_oi;
		r.date = start_date;
		r.tod = start_tod;
		return r;
	endfunction

	function automatic tick_t at_stamp(int unsigned y, int unsigned mo, int unsigned d,
			int unsigned h, int unsigned mi, int unsigned s, int unsigned ms);
		tick_t tk = '0;
		tk.year = 14'(y);
		tk.month = 4'(mo);
		tk.day = 5'(d);
		tk.hour = 5'(h);
		tk.minute = 6'(mi);
		tk.second = 6'(s);
		tk.milli = 10'(ms);
		tk.now_unix = 32'd1700000000;
		tk.tick_unix = tk.now_unix;
		return tk;
	endfunction

	// Advance the well-formed tick stream; a few items get raw random fields
	function automatic tick_t walk_tick();
		tick_t       tk;
		int unsigned off;
		case ($urandom_range(0, 7))
			1: walk.milli = 10'($urandom_range(0, 999));
			2: walk.second = 6'($urandom_range(0, 59));
			3: walk.minute = 6'($urandom_range(0, 59));
			4: walk.hour = 5'($urandom_range(0, 23));
			5: walk.day = 5'($urandom_range(1, 31));
			6: walk.month = 4'($urandom_range(1, 12));
			7: walk.year = 14'($urandom_range(0, 9999));
			default: ;
		endcase
		if ($urandom_range(0, 19) == 0) walk.close = 32'($urandom);
		else walk.close = walk.close + 32'($urandom_range(0, 2000)) - 32'd1000;
		if ($urandom_range(0, 19) == 0) walk.cum_vol = 40'({$urandom, $urandom});
		else walk.cum_vol = walk.cum_vol + 40'($urandom_range(0, 5000));
		walk.oi = 40'({$urandom, $urandom});
		// Keep most ticks fresh, some exactly at the limit, some just past it
		case ($urandom_range(0, 9))
			0: off = 32'(stale_cfg) + 1 + $urandom_range(0, 1000);
			1: off = 32'(stale_cfg);
			default: off = $urandom_range(0, 32'(stale_cfg));
		endcase
		walk.now_unix = $urandom;
		walk.tick_unix = $urandom_range(0, 1) ? walk.now_unix + off : walk.now_unix - off;
		tk = walk;
		if ($urandom_range(0, 99) < 8) begin
			tk.year = 14'($urandom);
			tk.month = 4'($urandom);
			tk.day = 5'($urandom);
			tk.hour = 5'($urandom);
			tk.minute = 6'($urandom);
			tk.second = 6'($urandom);
			tk.milli = 10'($urandom);
			tk.close = 32'($urandom);
			tk.cum_vol = 40'({$urandom, $urandom});
			if ($urandom_range(0, 1) == 1) begin
				tk.tick_unix = $urandom;
				tk.now_unix = $urandom;
			end
		end
		return tk;
	endfunction

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_PERIOD_UNIT:     unit_cfg = unit_t'(data[UNIT_W-1:0]);
			CFG_PERIOD_MULTIPLE: mult_cfg = data[MULT_W-1:0];
			CFG_STALE_LIMIT:     stale_cfg = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_period(unit_t unit, logic [CFG_DATA_W-1:0] mult,
			logic [CFG_DATA_W-1:0] stale);
		write_cfg(CFG_PERIOD_UNIT, CFG_DATA_W'(unit));
		write_cfg(CFG_PERIOD_MULTIPLE, mult);
		write_cfg(CFG_STALE_LIMIT, stale);
	endtask

	// Hold until no tick is queued, offered or awaiting its result; sample away
	// from the rising edge so the driver's updates have landed
	task automatic settle();
		while (pending_ticks.size() != 0 || in_valid || expected_bars.size() != 0)
			@(negedge clk);
	endtask

	// Drive ticks from the pending queue; predict each one as it is accepted
	always @(posedge clk) begin
		logic busy;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			busy = in_valid;
			if (in_valid && in_ready) begin
				expected_bars.push_back(predict_bar(tick_r));
				busy = 1'b0;
			end
			if (!busy) begin
				if (tx_gap != 0) begin
					tx_gap <= tx_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_ticks.size() != 0) begin
					tick_r <= pending_ticks.pop_front();
					in_valid <= 1'b1;
					tx_gap <= draw_gap(tx_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Take results with random stalls and check each against the oldest prediction
	always @(posedge clk) begin
		bar_t        got;
		bar_t        want;
		int unsigned hold;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			hold = rx_gap;
			if (out_valid && out_ready) begin
				got.st = status_t'(status);
				got.px_open = bar_open;
				got.px_high = bar_high;
				got.px_low = bar_low;
				got.px_close = bar_close;
				got.start_vol = bar_start_volume;
				got.oi = bar_open_interest;
				got.closed_vol = closed_bar_volume;
				got.closed_valid = closed_bar_valid;
				got.date = bar_date_stamp;
				got.tod = bar_time_stamp;
				if (expected_bars.size() == 0) begin
					bad_results++;
					if (bad_results <= MAX_REPORTS)
						$display("result %0d arrived with no tick pending", results_seen);
				end else begin
					want = expected_bars.pop_front();
					if (got !== want) begin
						bad_results++;
						if (bad_results <= MAX_REPORTS) begin
							$display("result %0d mismatch", results_seen);
							$display("  exp st=%0d o=%0d h=%0d l=%0d c=%0d sv=%0h oi=%0h cv=%0h/%0b d=%0d t=%0d",
								want.st, want.px_open, want.px_high, want.px_low,
								want.px_close, want.start_vol, want.oi, want.closed_vol,
								want.closed_valid, want.date, want.tod);
							$display("  got st=%0d o=%0d h=%0d l=%0d c=%0d sv=%0h oi=%0h cv=%0h/%0b d=%0d t=%0d",
								got.st, got.px_open, got.px_high, got.px_low,
								got.px_close, got.start_vol, got.oi, got.closed_vol,
								got.closed_valid, got.date, got.tod);
						end
					end
				end
				results_seen++;
				hold = draw_gap(rx_calm);
			end
			if (hold != 0) begin
				out_ready <= 1'b0;
				rx_gap <= hold - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Abort a hung run
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL tick_to_ohlc_bar_aggregator");
		$finish;
	end

	initial begin
		tick_t            tk;
		int unsigned      ph;
		unit_t            unit;
		logic [CFG_DATA_W-1:0] mult;
		logic [CFG_DATA_W-1:0] stale;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: minute bars, one boundary each, 180 s stale window
		tk = at_stamp(2024, 3, 15, 9, 30, 0, 0);
		tk.tick_unix = tk.now_unix + 32'd181;                 // stale before any bar
		pending_ticks.push_back(tk);
		tk.tick_unix = tk.now_unix + 32'd180;                 // first tick opens a bar
		tk.close = 32'sh80000000;
		tk.cum_vol = 40'd1000;
		tk.oi = 40'd5;
		pending_ticks.push_back(tk);
		tk = at_stamp(2024, 3, 15, 9, 30, 15, 0);
		tk.tick_unix = tk.now_unix - 32'd180;
		tk.close = 32'sh7FFFFFFF;
		tk.cum_vol = 40'd1200;
		pending_ticks.push_back(tk);
		tk = at_stamp(2024, 3, 15, 9, 30, 59, 999);
		tk.cum_vol = 40'd1300;
		pending_ticks.push_back(tk);
		tk = at_stamp(2024, 3, 15, 9, 31, 0, 0);               // volume below bar start
		tk.close = 32'sd77;
		tk.cum_vol = 40'd10;
		pending_ticks.push_back(tk);
		tk = at_stamp(2024, 3, 15, 9, 31, 1, 0);
		tk.tick_unix = 32'd0;
		tk.now_unix = 32'hFFFFFFFF;
		pending_ticks.push_back(tk);
		tk.tick_unix = 32'hFFFFFFFF;
		tk.now_unix = 32'd0;
		pending_ticks.push_back(tk);
		tk = at_stamp(16383, 15, 31, 31, 63, 63, 1023);       // stamps past their ranges
		tk.close = -32'sd1;
		tk.cum_vol = '1;
		tk.oi = '1;
		pending_ticks.push_back(tk);
		tk = at_stamp(0, 0, 0, 0, 0, 0, 0);
		tk.close = 32'sd1;
		pending_ticks.push_back(tk);
		tk.milli = 10'd1;
		pending_ticks.push_back(tk);
		settle();

		// Millisecond bars, zero multiple (bit 11 dropped), exact-time ticks only
		set_period(UNIT_MILLI, 16'h0800, 16'd0);
		tk.milli = 10'd2;
		pending_ticks.push_back(tk);
		pending_ticks.push_back(tk);
		tk.milli = 10'd3;
		tk.tick_unix = tk.now_unix + 32'd1;
		pending_ticks.push_back(tk);
		tk.tick_unix = tk.now_unix;
		pending_ticks.push_back(tk);
		settle();

		// Hour bars with saturated multiple, widest stale window, spare index
		write_cfg(CFG_SPARE, 16'hFFFF);
		set_period(UNIT_HOUR, 16'hFFFF, 16'hFFFF);
		tk.minute = 6'd1;
		tk.tick_unix = tk.now_unix - 32'd65535;
		pending_ticks.push_back(tk);
		tk.tick_unix = tk.now_unix + 32'd65536;
		pending_ticks.push_back(tk);
		tk.tick_unix = tk.now_unix;
		tk.hour = 5'd1;
		pending_ticks.push_back(tk);
		settle();

		// Lower the multiple below the running count
		set_period(UNIT_MINUTE, 16'd2, STALE_RESET);
		tk.minute = 6'd5;
		pending_ticks.push_back(tk);
		tk.minute = 6'd6;
		pending_ticks.push_back(tk);
		tk.minute = 6'd7;
		pending_ticks.push_back(tk);
		walk = tk;

		// Random phases: every unit with small multiples first, then mixed settings
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			if (ph < 8) begin
				unit = unit_t'(ph[UNIT_W-1:0]);
				case (ph)
					2, 3, 5: mult = 16'd0;
					1, 6:    mult = 16'd2;
					default: mult = 16'd1;
				endcase
			end else begin
				unit = unit_t'($urandom_range(0, 7));
				case (ph)
					8:       mult = 16'hFFFF;
					9:       mult = 16'd1024;
					default: mult = 16'($urandom_range(0, 4));
				endcase
			end
			case (ph == 1 ? 0 : ph == 2 ? 1 : $urandom_range(0, 5))
				0:       stale = 16'd0;
				1:       stale = 16'hFFFF;
				2:       stale = 16'($urandom);
				default: stale = STALE_RESET;
			endcase
			set_period(unit, mult, stale);
			tx_calm = $urandom_range(0, 3) == 0;
			rx_calm = $urandom_range(0, 3) == 0;
			repeat (ITEMS_PER_PHASE) pending_ticks.push_back(walk_tick());
		end
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (bad_results == 0 && expected_bars.size() == 0)
			$display("PASS tick_to_ohlc_bar_aggregator");
		else
			$display("FAIL tick_to_ohlc_bar_aggregator");
		$finish;
	end

endmodule
